// ===== sv/bounded_lifo_stack_core_defines.svh =====
// Assertion macros shared by the stack core.
`ifndef BOUNDED_LIFO_STACK_CORE_DEFINES_SVH
`define BOUNDED_LIFO_STACK_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bls_pkg.sv =====
// Types and constants of the bounded LIFO stack core.
package bls_pkg;

  localparam int InDataW  = 32;
  localparam int OutDataW = 32;
  localparam int CfgW     = 7;
  localparam logic [CfgW-1:0] CapLimitReset = 7'd64;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DUMP = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push_wr;    // write the pushed item and bump the count
    logic    pop_dec;    // drop the top entry
    logic    rd_top;     // read the top entry, load the walk pointer
    logic    rd_next;    // read the entry below the walk pointer
    logic    out_load;   // load the output register
    logic    out_mem;    // output data from memory, else zero
    status_e out_status;
    logic    out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic ptr_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/bls_in_if.sv =====
// Input channel: one stack operation per item.
interface bls_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic signed [bls_pkg::InDataW-1:0] push_value;

  modport source (output valid, opcode, push_value, input ready);
  modport sink   (input valid, opcode, push_value, output ready);
endinterface

// ===== sv/bls_out_if.sv =====
// Output channel: one result per item.
interface bls_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bls_pkg::OutDataW-1:0] data_value;
  logic [1:0]                          status_code;
  logic                                last_of_run;

  modport source (output valid, data_value, status_code, last_of_run, input ready);
  modport sink   (input valid, data_value, status_code, last_of_run, output ready);
endinterface

// ===== sv/bls_cfg_if.sv =====
// Configuration write channel for the capacity limit.
interface bls_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bls_pkg::CfgW-1:0]  capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

// ===== sv/bls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bls_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/bls_ctrl.sv =====
// Controller: decodes operations and sequences memory reads for pop, peek and dump.
module bls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    opcode_i,
  output logic          in_ready_o,
  input  bls_pkg::sts_t sts_i,
  output bls_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   single_q, single_d;
  logic   in_fire;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    single_d          = single_q;
    cmd_o             = '0;
    cmd_o.out_status  = bls_pkg::STATUS_OK;
    cmd_o.out_last    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (bls_pkg::opcode_e'(opcode_i))
            bls_pkg::OP_PUSH: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = bls_pkg::STATUS_OVERFLOW;
              end else begin
                cmd_o.push_wr = 1'b1;
              end
            end
            bls_pkg::OP_POP, bls_pkg::OP_PEEK: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = bls_pkg::STATUS_UNDERFLOW;
              end else begin
                cmd_o.rd_top  = 1'b1;
                cmd_o.pop_dec = (bls_pkg::opcode_e'(opcode_i) == bls_pkg::OP_POP);
                single_d      = 1'b1;
                state_d       = ST_FETCH;
              end
            end
            default: begin
              // dump: walk from the top down
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = bls_pkg::STATUS_UNDERFLOW;
              end else begin
                cmd_o.rd_top = 1'b1;
                single_d     = 1'b0;
                state_d      = ST_FETCH;
              end
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_mem  = 1'b1;
          cmd_o.out_last = single_q || sts_i.ptr_zero;
          if (single_q || sts_i.ptr_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      single_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      single_q <= single_d;
    end
  end

endmodule

// ===== sv/bls_dp.sv =====
// Datapath: entry store, count, limit, walk pointer and output register.
module bls_dp #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bls_pkg::cmd_t                       cmd_i,
  output bls_pkg::sts_t                       sts_o,
  input  logic signed [bls_pkg::InDataW-1:0]  push_value_i,
  input  logic                                cfg_we_i,
  input  logic [bls_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [bls_pkg::OutDataW-1:0] data_value_o,
  output logic [1:0]                          status_code_o,
  output logic                                last_of_run_o
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);

  logic [CntW-1:0]            count_q, count_d;
  logic [bls_pkg::CfgW-1:0]   limit_q;
  logic [AddrW-1:0]           ptr_q, ptr_d;
  logic [AddrW-1:0]           top_addr, rd_addr;
  logic [DATA_WIDTH-1:0]      wr_data, rd_data;
  logic                       out_valid_q, out_valid_d;
  logic signed [bls_pkg::OutDataW-1:0] data_q;
  logic [1:0]                 status_q;
  logic                       last_q;

  assign top_addr = AddrW'(count_q - CntW'(1));
  assign rd_addr  = cmd_i.rd_top ? top_addr : (ptr_q - AddrW'(1));
  assign wr_data  = DATA_WIDTH'(push_value_i);

  bls_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.push_wr),
    .wr_addr_i (AddrW'(count_q)),
    .wr_data_i (wr_data),
    .re_i      (cmd_i.rd_top || cmd_i.rd_next),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.push_wr) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop_dec) begin
      count_d = count_q - CntW'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.rd_top || cmd_i.rd_next) begin
      ptr_d = rd_addr;
    end
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (bls_pkg::CfgW'(count_q) >= limit_q) || (count_q == CntW'(DEPTH));
  assign sts_o.ptr_zero = (ptr_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= bls_pkg::CapLimitReset;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Result payload, sign-extended from the stored width.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      data_q   <= cmd_i.out_mem ? bls_pkg::OutDataW'($signed(rd_data)) : '0;
      status_q <= cmd_i.out_status;
      last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_value_o  = data_q;
  assign status_code_o = status_q;
  assign last_of_run_o = last_q;

endmodule

// ===== sv/bounded_lifo_stack_core.sv =====
// Bounded LIFO stack core: push, pop, peek and dump over an entry RAM.
// Push and every underflow/overflow result: registered at accept.
// Pop and peek: registered RAM read, then load of the output register.
// Dump of N entries: registered RAM reads from the top down, one result per cycle while the sink keeps up.
// The RAM has a single read port; input is held while a read is pending.
// Reset (rst_ni low, async): stack empty, capacity limit 64, no result pending.
`include "bounded_lifo_stack_core_defines.svh"

module bounded_lifo_stack_core #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  bls_in_if.sink    in_i,
  bls_out_if.source out_o,
  bls_cfg_if.sink   cfg_i
);

  bls_pkg::cmd_t cmd;
  bls_pkg::sts_t sts;

  // The limit register is always writable; software must write it only while idle (the block does not enforce this).
  assign cfg_i.ready = 1'b1;

  // Controller: decode the item, hold input while a memory read is in flight.
  bls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .opcode_i   (in_i.opcode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: store, count, walk pointer and output register.
  bls_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .push_value_i  (in_i.push_value),
    .cfg_we_i      (cfg_i.valid && cfg_i.ready),
    .cfg_data_i    (cfg_i.capacity_limit),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .data_value_o  (out_o.data_value),
    .status_code_o (out_o.status_code),
    .last_of_run_o (out_o.last_of_run)
  );

  // Never write past the capacity limit.
  `BLS_ASSERT_NOW(a_push_room, cmd.push_wr, !sts.full, "push written while stack full")
  // Never read the top of an empty stack.
  `BLS_ASSERT_NOW(a_read_nonempty, cmd.rd_top, !sts.empty, "read issued on empty stack")
  // Error results carry zero data and close the run.
  `BLS_ASSERT_NOW(a_err_shape, out_o.valid && (out_o.status_code != bls_pkg::STATUS_OK), out_o.last_of_run && (out_o.data_value == '0), "malformed error result")
  // An accepted push shows its single result in the next cycle.
  `BLS_ASSERT_NEXT(a_push_result, in_i.valid && in_i.ready && (in_i.opcode == bls_pkg::OP_PUSH), out_o.valid && out_o.last_of_run, "push result missing")

endmodule

// ===== verif/tb_bounded_lifo_stack_core.sv =====
// Self-checking testbench for the bounded LIFO stack core: random and directed stack operations.
module tb_bounded_lifo_stack_core;
  import bls_pkg::*;

  localparam int StackDepth  = 64;
  localparam int QuietLimit  = 2000;  // cycles with no handshake before giving up
  localparam int DrainCycles = 70;    // covers a full dump of StackDepth entries

  // One stack operation waiting to be offered to the block.
  typedef struct {
    opcode_e           opcode;
    logic signed [31:0] value;
  } stack_op_t;

  // One result the block owes us.
  typedef struct packed {
    logic signed [31:0] data;
    status_e            status;
    logic               last;
  } stack_result_t;

  logic clk_i;
  logic rst_ni;

  bls_in_if  in_if ();
  bls_out_if out_if ();
  bls_cfg_if cfg_if ();

  bounded_lifo_stack_core #(
    .DEPTH     (StackDepth),
    .DATA_WIDTH(InDataW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Shadow copy of the stack, kept in step with accepted operations.
  logic signed [31:0] shadow_entries [StackDepth];
  int unsigned        shadow_count = 0;
  logic [CfgW-1:0]    shadow_limit = CapLimitReset;

  stack_op_t       op_backlog[$];
  stack_result_t   owed_results[$];
  logic [CfgW-1:0] limit_writes[$];

  logic        no_idle = 1'b0;  // set for one phase: both sides run flat out
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // Apply one accepted operation to the shadow stack and queue what it must produce.
  function void stack_apply(opcode_e op, logic signed [31:0] value);
    int unsigned   room;
    stack_result_t res;
    room = (shadow_limit > StackDepth) ? StackDepth : shadow_limit;
    res.data = '0;
    res.last = 1'b1;
    case (op)
      OP_PUSH: begin
        // Full (or limit lowered under the count): leave the stack alone.
        if (shadow_count >= room) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          shadow_entries[shadow_count] = value;
          shadow_count++;
          res.status = STATUS_OK;
        end
        owed_results.push_back(res);
      end
      OP_POP, OP_PEEK: begin
        if (shadow_count == 0) begin
          res.status = STATUS_UNDERFLOW;
        end else begin
          res.data   = shadow_entries[shadow_count-1];
          res.status = STATUS_OK;
          if (op == OP_POP) shadow_count--;
        end
        owed_results.push_back(res);
      end
      default: begin
        // Dump walks top to bottom and flags the bottom entry; empty gives one underflow.
        if (shadow_count == 0) begin
          res.status = STATUS_UNDERFLOW;
          owed_results.push_back(res);
        end else begin
          for (int unsigned i = shadow_count; i > 0; i--) begin
            res.data   = shadow_entries[i-1];
            res.status = STATUS_OK;
            res.last   = (i == 1);
            owed_results.push_back(res);
          end
        end
      end
    endcase
  endfunction

  // Input driver: hold a stalled item, otherwise offer the next one or idle at random.
  always @(posedge clk_i) begin
    logic send;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        void'(op_backlog.pop_front());
        stack_apply(opcode_e'(in_if.opcode), in_if.push_value);
      end
      if (!(in_if.valid && !in_if.ready)) begin
        send = (op_backlog.size() != 0) && (no_idle || $urandom_range(99) >= 37);
        in_if.valid <= send;
        if (send) begin
          in_if.opcode     <= op_backlog[0].opcode;
          in_if.push_value <= op_backlog[0].value;
        end
      end
    end
  end

  // Configuration driver: the shadow limit changes only when the write is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        shadow_limit = cfg_if.capacity_limit;
        void'(limit_writes.pop_front());
      end
      if (limit_writes.size() != 0) begin
        cfg_if.valid          <= 1'b1;
        cfg_if.capacity_limit <= limit_writes[0];
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  // Output monitor: throttle ready and check every accepted result against the oldest owed one.
  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: data_value %0d status_code %0d last_of_run %0d",
                 out_if.data_value, out_if.status_code, out_if.last_of_run);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_if.data_value !== want.data) begin
            $error("data_value: expected %0d, got %0d", want.data, out_if.data_value);
            fail_count++;
          end
          if (out_if.status_code !== want.status) begin
            $error("status_code: expected %0d, got %0d", want.status, out_if.status_code);
            fail_count++;
          end
          if (out_if.last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_if.last_of_run);
            fail_count++;
          end
        end
      end
      out_if.ready <= no_idle || ($urandom_range(99) >= 37);
    end
  end

  // Watchdog: end the run once no channel has moved anything for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_op(opcode_e op, logic signed [31:0] value);
    stack_op_t item;
    item.opcode = op;
    item.value  = value;
    op_backlog.push_back(item);
  endtask

  // Hold the sender until every item is taken and every result is back, then let the
  // block go quiet before anything else happens.
  task automatic settle();
    while (op_backlog.size() != 0 || in_if.valid || owed_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_limit(logic [CfgW-1:0] limit);
    settle();
    limit_writes.push_back(limit);
    while (limit_writes.size() != 0 || cfg_if.valid) @(negedge clk_i);
  endtask

  // Write the limit, then queue a batch of operations drawn with the given weights
  // (percent; dump takes what is left).
  task automatic run_random(logic [CfgW-1:0] limit, int unsigned count,
                            int unsigned push_w, int unsigned pop_w, int unsigned peek_w);
    int unsigned pick;
    opcode_e     op;
    set_limit(limit);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < push_w)                       op = OP_PUSH;
      else if (pick < push_w + pop_w)          op = OP_POP;
      else if (pick < push_w + pop_w + peek_w) op = OP_PEEK;
      else                                     op = OP_DUMP;
      queue_op(op, $urandom());
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.opcode          = OP_PUSH;
    in_if.push_value      = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.capacity_limit = CapLimitReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset limit: underflow on an empty stack, extreme values, then unwind.
    queue_op(OP_POP, 32'sd5);
    queue_op(OP_PEEK, -32'sd5);
    queue_op(OP_DUMP, '0);
    queue_op(OP_PUSH, 32'sh7FFF_FFFF);
    queue_op(OP_PUSH, 32'sh8000_0000);
    queue_op(OP_PUSH, 32'sh0000_0000);
    queue_op(OP_PUSH, 32'shFFFF_FFFF);
    queue_op(OP_PEEK, '0);
    queue_op(OP_DUMP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_POP, '0);

    // Limit of one with two entries held: pushes overflow until the count drops below it.
    set_limit(7'd1);
    queue_op(OP_PUSH, 32'sd11);
    queue_op(OP_PEEK, '0);
    queue_op(OP_DUMP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_PUSH, 32'sd12);
    queue_op(OP_POP, '0);
    queue_op(OP_PUSH, 32'sh5555_AAAA);
    queue_op(OP_PUSH, 32'shAAAA_5555);

    // Limit of zero: every push overflows, reads still work.
    set_limit(7'd0);
    queue_op(OP_PUSH, 32'sd13);
    queue_op(OP_DUMP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_POP, '0);

    // Limit above the store size: fill to the real depth and hit overflow there.
    run_random(7'd127, 90, 80, 5, 7);
    // Drop the limit far under the count: overflow until pops bring the count down.
    run_random(7'd5, 40, 20, 50, 15);
    // Drain past empty.
    run_random(7'd64, 50, 10, 60, 15);
    run_random(7'd3, 30, 45, 25, 15);
    // One stretch with no idling on either side.
    no_idle = 1'b1;
    run_random(7'($urandom_range(StackDepth, 1)), 40, 40, 30, 15);
    settle();
    no_idle = 1'b0;
    run_random(7'd0, 15, 40, 20, 20);
    run_random(7'd64, 55, 50, 25, 12);
    settle();

    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bls_pkg.sv
sv/bls_in_if.sv
sv/bls_out_if.sv
sv/bls_cfg_if.sv
sv/bls_ram.sv
sv/bls_ctrl.sv
sv/bls_dp.sv
sv/bounded_lifo_stack_core.sv
verif/tb_bounded_lifo_stack_core.sv
